// ----- hw/rtl/pttfsm_pkg.sv -----
// ----------------------------------------------------------------------------
// pttfsm_pkg
// Shared constants, codes and types of the programmable transition-table
// state machine: table sizing, command and outcome codes, and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pttfsm_pkg;

	// Table and field sizing.
	localparam int MAX_LINKS  = 64;
	localparam int STATE_BITS = 8;
	localparam int EVENT_BITS = 8;
	localparam int LINK_AW    = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
	localparam int CNT_W      = $clog2(MAX_LINKS + 1);
	localparam int NUM_STATES = 1 << STATE_BITS;

	// Command codes.
	localparam logic [1:0] CMD_LINK    = 2'd0;
	localparam logic [1:0] CMD_SET_CUR = 2'd1;
	localparam logic [1:0] CMD_SET_RPT = 2'd2;
	localparam logic [1:0] CMD_PUSH    = 2'd3;

	// Outcome codes.
	localparam logic [1:0] OUT_TRANS     = 2'd0;
	localparam logic [1:0] OUT_UNMATCHED = 2'd1;
	localparam logic [1:0] OUT_NO_STATE  = 2'd2;
	localparam logic [1:0] OUT_FULL      = 2'd3;

	// One entry of the transition table.
	typedef struct packed {
		logic [STATE_BITS-1:0] src;
		logic [EVENT_BITS-1:0] evt;
		logic [STATE_BITS-1:0] tgt;
	} link_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic       accept;      // transaction taken this cycle
		logic       scan_issue;  // read the link at the scan index
		logic       take_target; // move to the matched link's target
		logic       emit;        // load the result register
		logic [1:0] outcome;
	} ctl_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic en;        // error reporting enabled
		logic cur_valid; // a current state has been set
		logic full;      // table holds MAX_LINKS entries
		logic cnt_zero;  // table is empty
		logic hit;       // the link read last cycle matches
		logic last;      // the link read last cycle is the final one
		logic flag;      // report flag of the new state
	} dp_sts_t;

endpackage

// ----- hw/rtl/pttfsm_dp.sv -----
// ----------------------------------------------------------------------------
// pttfsm_dp
// Datapath: transition table memory with its fill count, report flag memory,
// current state, scan index and compare stage, configuration register and the
// result register.
// ----------------------------------------------------------------------------
module pttfsm_dp
	import pttfsm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctl_cmd_t              ctl,
	output dp_sts_t               sts,
	input  logic [1:0]            command,
	input  logic [STATE_BITS-1:0] src_state,
	input  logic [EVENT_BITS-1:0] event_code,
	input  logic [STATE_BITS-1:0] dst_state,
	input  logic                  report_on,
	input  logic                  cfg_valid,
	input  logic                  cfg_data,
	output logic                  result_valid,
	output logic [1:0]            outcome,
	output logic [STATE_BITS-1:0] previous_state,
	output logic [EVENT_BITS-1:0] event_seen,
	output logic [STATE_BITS-1:0] next_state
);

	link_t                 link_mem [MAX_LINKS];
	logic                  flag_mem [NUM_STATES];
	logic [NUM_STATES-1:0] flag_vld_q;

	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      idx_q;
	logic [CNT_W-1:0]      idx_s1;
	logic                  pend_s1;
	link_t                 link_s1;
	logic                  flag_s1;
	logic                  flag_vld_s1;
	logic                  en_q;
	logic [STATE_BITS-1:0] cur_q;
	logic                  cur_vld_q;
	logic [STATE_BITS-1:0] prev_q;
	logic [EVENT_BITS-1:0] ev_q;
	logic                  res_vld_q;
	logic [1:0]            res_out_q;
	logic [STATE_BITS-1:0] res_prev_q;
	logic [EVENT_BITS-1:0] res_ev_q;
	logic [STATE_BITS-1:0] res_next_q;
	logic                  full;
	logic                  link_wr;

	assign full    = (count_q == CNT_W'(MAX_LINKS));
	assign link_wr = ctl.accept && (command == CMD_LINK) && !full;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b0;
		end else if (cfg_valid) begin
			en_q <= cfg_data;
		end
	end

	// Transition table: one write port for appends, one registered read port.
	always_ff @(posedge clk) begin
		if (link_wr) begin
			link_mem[count_q[LINK_AW-1:0]] <= '{src: src_state, evt: event_code,
				tgt: dst_state};
		end
		link_s1 <= link_mem[idx_q[LINK_AW-1:0]];
	end

	// Fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (link_wr) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// Scan index and the read-pending stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= ctl.scan_issue;
			if (ctl.accept) begin
				idx_q <= '0;
			end else if (ctl.scan_issue) begin
				idx_q <= idx_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
	end

	// Report flags: memory plus one valid bit per state, so an unwritten
	// flag reads as cleared.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_vld_q <= '0;
		end else if (ctl.accept && (command == CMD_SET_RPT)) begin
			flag_vld_q[src_state] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept && (command == CMD_SET_RPT)) begin
			flag_mem[src_state] <= report_on;
		end
		flag_s1     <= flag_mem[link_s1.tgt];
		flag_vld_s1 <= flag_vld_q[link_s1.tgt];
	end

	// Current state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= '0;
			cur_vld_q <= 1'b0;
		end else if (ctl.accept && (command == CMD_SET_CUR)) begin
			cur_q     <= src_state;
			cur_vld_q <= 1'b1;
		end else if (ctl.take_target) begin
			cur_q <= link_s1.tgt;
		end
	end

	// Event held for the length of a scan; previous state taken with the target.
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			ev_q <= event_code;
		end
		if (ctl.take_target) begin
			prev_q <= cur_q;
		end
	end

	// Result register: the strobe lasts one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else begin
			res_vld_q <= ctl.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			res_out_q  <= ctl.outcome;
			res_prev_q <= (ctl.outcome == OUT_TRANS) ? prev_q : cur_q;
			res_ev_q   <= ctl.accept ? event_code : ev_q;
			res_next_q <= cur_q;
		end
	end

	// Status toward the controller.
	always_comb begin
		sts.en        = en_q;
		sts.cur_valid = cur_vld_q;
		sts.full      = full;
		sts.cnt_zero  = (count_q == '0);
		sts.hit       = pend_s1 && (link_s1.src == cur_q) && (link_s1.evt == ev_q);
		sts.last      = pend_s1 && (idx_s1 == count_q - CNT_W'(1));
		sts.flag      = flag_s1 && flag_vld_s1;
	end

	assign result_valid   = res_vld_q;
	assign outcome        = res_out_q;
	assign previous_state = res_prev_q;
	assign event_seen     = res_ev_q;
	assign next_state     = res_next_q;

	// The scan never reads past the filled part of the table.
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.scan_issue |-> (idx_q < count_q))
		else $error("scan index beyond fill count");

	// The fill count never exceeds the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_LINKS))
		else $error("fill count overflow");

	// A link is appended only when the table had room.
	a_append: assert property (@(posedge clk) disable iff (!arst_n)
		link_wr |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("append did not advance fill count");

endmodule

// ----- hw/rtl/pttfsm_ctrl.sv -----
// ----------------------------------------------------------------------------
// pttfsm_ctrl
// Controller: accepts transactions, runs the link scan of a pushed event and
// decides which result, if any, is produced.
// ----------------------------------------------------------------------------
module pttfsm_ctrl
	import pttfsm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] command,
	input  dp_sts_t    sts,
	output ctl_cmd_t   ctl,
	output logic       busy
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FLAG = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       more;

	// Scan continues while unread links remain and no match was found.
	assign more = !sts.hit && !sts.last;

	// Next state and commands.
	always_comb begin
		state_d         = state_q;
		ctl.accept      = 1'b0;
		ctl.scan_issue  = 1'b0;
		ctl.take_target = 1'b0;
		ctl.emit        = 1'b0;
		ctl.outcome     = OUT_TRANS;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.accept = 1'b1;
					if (command == CMD_LINK && sts.full) begin
						ctl.emit    = 1'b1;
						ctl.outcome = OUT_FULL;
					end else if (command == CMD_PUSH) begin
						if (!sts.cur_valid) begin
							ctl.emit    = sts.en;
							ctl.outcome = OUT_NO_STATE;
						end else if (sts.cnt_zero) begin
							ctl.emit    = sts.en;
							ctl.outcome = OUT_UNMATCHED;
						end else begin
							state_d = ST_SCAN;
						end
					end
				end
			end
			ST_SCAN: begin
				// The index has no bound of its own in the datapath, so issuing past the
				// end is masked here by the last-link status.
				ctl.scan_issue = more && !(state_q == ST_SCAN && sts.hit);
				if (sts.hit) begin
					ctl.take_target = 1'b1;
					ctl.scan_issue  = 1'b0;
					state_d         = ST_FLAG;
				end else if (sts.last) begin
					ctl.scan_issue = 1'b0;
					ctl.emit       = sts.en;
					ctl.outcome    = OUT_UNMATCHED;
					state_d        = ST_IDLE;
				end
			end
			ST_FLAG: begin
				ctl.emit    = sts.flag;
				ctl.outcome = OUT_TRANS;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	// A match during the scan always leads to the flag lookup.
	a_hit_to_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && sts.hit) |=> (state_q == ST_FLAG))
		else $error("match did not lead to flag lookup");

	// The flag lookup returns to idle in the next cycle.
	a_flag_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLAG) |=> (state_q == ST_IDLE))
		else $error("flag lookup did not finish");

	// A push with a state set and a non-empty table starts a scan.
	a_push_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.accept && command == CMD_PUSH && sts.cur_valid && !sts.cnt_zero)
		|=> (state_q == ST_SCAN))
		else $error("push did not start a scan");

	// No transaction is taken while busy.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !ctl.accept)
		else $error("transaction taken while busy");

endmodule

// ----- hw/rtl/programmable_transition_table_fsm_core.sv -----
// ----------------------------------------------------------------------------
// programmable_transition_table_fsm_core
// Programmable table-driven state machine: link, set-state, set-flag and
// push-event commands over a flat transition table.
// ----------------------------------------------------------------------------
// Results: a full table, or a push error while error reporting is enabled,
// strobes in the cycle after acceptance. A matched push moves to the link's
// target and strobes only if that state's report flag is set; an unmatched
// push strobes after the final link if error reporting is enabled.
// Throughput: one link per cycle through the single table read port; no new
// command is taken while a push is busy. The receiver cannot stall. Reset
// clears the table, state, report flags and error enable; no clearing pass.
module programmable_transition_table_fsm_core
	import pttfsm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            command,
	input  logic [STATE_BITS-1:0] src_state,
	input  logic [EVENT_BITS-1:0] event_code,
	input  logic [STATE_BITS-1:0] dst_state,
	input  logic                  report_on,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_data,
	output logic                  result_valid,
	output logic [1:0]            outcome,
	output logic [STATE_BITS-1:0] previous_state,
	output logic [EVENT_BITS-1:0] event_seen,
	output logic [STATE_BITS-1:0] next_state
);

	ctl_cmd_t ctl;
	dp_sts_t  sts;

	// The configuration register takes a write in any cycle.
	assign cfg_ready = 1'b1;

	// Controller.
	pttfsm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.sts     (sts),
		.ctl     (ctl),
		.busy    (busy)
	);

	// Datapath.
	pttfsm_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.sts            (sts),
		.command        (command),
		.src_state      (src_state),
		.event_code     (event_code),
		.dst_state      (dst_state),
		.report_on      (report_on),
		.cfg_valid      (cfg_valid),
		.cfg_data       (cfg_data),
		.result_valid   (result_valid),
		.outcome        (outcome),
		.previous_state (previous_state),
		.event_seen     (event_seen),
		.next_state     (next_state)
	);

endmodule
